// ===== hw/rtl/logistic_regression_trainer_assert.svh =====
// Assertion macros for the logistic regression trainer.
// Both sample on the rising edge of clk and are held off while rst_n is low.
`ifndef LOGISTIC_REGRESSION_TRAINER_ASSERT_SVH
`define LOGISTIC_REGRESSION_TRAINER_ASSERT_SVH

// Generic property check
`define LRT_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lrt assertion failed");

// Check that a condition is followed by a consequence in the next cycle
`define LRT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrt sequence assertion failed");

`endif

// ===== hw/rtl/lrt_pkg.sv =====
// ---------------------------------------------------------------------------
// lrt_pkg
// Shared constants and types for the logistic regression trainer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrt_pkg;

  // Sample store
  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;

  // Field widths
  localparam int X_W   = 16;
  localparam int CFG_W = 16;
  localparam int MDL_W = 32;
  localparam int SUM_W = 48;

  // Divider: magnitude of (rate * sum) >> 16
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Register reset values
  localparam logic [CFG_W-1:0] LR_RESET    = 16'd655;
  localparam logic [CFG_W-1:0] EPOCH_RESET = 16'd100;

  // Register indexes
  localparam logic REG_LR    = 1'b0;
  localparam logic REG_EPOCH = 1'b1;

  // Result kinds
  localparam logic KIND_TRAIN   = 1'b0;
  localparam logic KIND_PREDICT = 1'b1;

  // Operations
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PREDICT = 1'b1;

  typedef struct packed {
    logic                  label;
    logic signed [X_W-1:0] x;
  } sample_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lrt_store.sv =====
// ---------------------------------------------------------------------------
// lrt_store
// Sample memory: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrt_store (
  input  wire                          clk,
  input  wire                          we,
  input  wire [lrt_pkg::ADDR_W-1:0]    waddr,
  input  lrt_pkg::sample_t             wdata,
  input  wire [lrt_pkg::ADDR_W-1:0]    raddr,
  output lrt_pkg::sample_t             rdata
);

  lrt_pkg::sample_t mem_r [lrt_pkg::MAX_SAMPLES];
  lrt_pkg::sample_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lrt_div.sv =====
// ---------------------------------------------------------------------------
// lrt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrt_div (
  input  wire                           clk,
  input  wire                           rst_n,
  input  lrt_pkg::div_req_t             req,
  output logic                          done,
  output logic [lrt_pkg::DIV_W-1:0]     quotient
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [lrt_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [lrt_pkg::CNT_W-1:0]        rem_r, rem_nxt;
  logic [lrt_pkg::DIV_W-1:0]        quo_r, quo_nxt;
  logic [lrt_pkg::CNT_W-1:0]        den_r, den_nxt;
  logic [lrt_pkg::CNT_W:0]          trial;
  logic [lrt_pkg::CNT_W:0]          diff;
  logic                             fits;

  // One shift-subtract step
  always_comb begin
    trial = {rem_r, quo_r[lrt_pkg::DIV_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = (trial >= {1'b0, den_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[lrt_pkg::CNT_W-1:0] : trial[lrt_pkg::CNT_W-1:0];
      quo_nxt = {quo_r[lrt_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == lrt_pkg::DIV_CNT_W'(lrt_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/logistic_regression_trainer.sv =====
// ---------------------------------------------------------------------------
// logistic_regression_trainer
// Single-feature logistic regression: loads samples, trains by batch
// gradient descent on a shared multiplier and serial divider, predicts.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | op, sample_x, sample_y, last
//  out_    | output    | out_valid/out_ready | kind, weight_out, bias_out,
//          |           |                     | predicted_class
//  cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
//  A load request without last leaves the block idle. A predict request steps
//  through S_PMUL, S_PZ and S_EMIT to its result. Training runs epochs passes
//  over n stored samples: S_RD, S_MZ, S_SIG, S_ME, S_ACC per sample on the
//  shared multiplier, and two updates per epoch, mostly the 48-step divider.
//  Reset is synchronous; in_ready is low while a request is being worked on
//  or its result waits for an output slot; a stalled result holds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module logistic_regression_trainer (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                in_op,
  input  wire signed [15:0]  in_sample_x,
  input  wire signed [15:0]  in_sample_y,
  input  wire                in_last,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               out_kind,
  output logic signed [31:0] out_weight_out,
  output logic signed [31:0] out_bias_out,
  output logic               out_predicted_class,
  input  wire                cfg_we,
  input  wire [0:0]          cfg_index,
  input  wire [15:0]         cfg_wdata
);

  typedef enum logic [15:0] {
    S_IDLE = 16'b0000_0000_0000_0001,
    S_EP   = 16'b0000_0000_0000_0010,
    S_RD   = 16'b0000_0000_0000_0100,
    S_MZ   = 16'b0000_0000_0000_1000,
    S_SIG  = 16'b0000_0000_0001_0000,
    S_ME   = 16'b0000_0000_0010_0000,
    S_ACC  = 16'b0000_0000_0100_0000,
    S_UABS = 16'b0000_0000_1000_0000,
    S_UMH  = 16'b0000_0001_0000_0000,
    S_UML  = 16'b0000_0010_0000_0000,
    S_UMA  = 16'b0000_0100_0000_0000,
    S_UDIV = 16'b0000_1000_0000_0000,
    S_UAPP = 16'b0001_0000_0000_0000,
    S_PMUL = 16'b0010_0000_0000_0000,
    S_PZ   = 16'b0100_0000_0000_0000,
    S_EMIT = 16'b1000_0000_0000_0000
  } state_t;

  localparam int PROD_W = 58;
  localparam int Z_W    = 51;
  localparam int ACC_W  = 50;
  localparam logic signed [Z_W-1:0] SIG_HI = 51'sd524288;
  localparam logic signed [Z_W-1:0] SIG_LO = -51'sd524288;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [lrt_pkg::CFG_W-1:0] lr_r, epochs_r;

  // Load-side state
  logic [lrt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [lrt_pkg::CNT_W-1:0] n_r, n_nxt;
  logic signed [15:0]        prev_y_r, prev_y_nxt;

  // Model and training state
  logic signed [31:0]        w_r, w_nxt, b_r, b_nxt;
  logic signed [47:0]        wsum_r, wsum_nxt, bsum_r, bsum_nxt;
  logic [lrt_pkg::ADDR_W-1:0] idx_r, idx_nxt;
  logic [lrt_pkg::CFG_W-1:0] epoch_r, epoch_nxt;
  logic                      sel_r, sel_nxt;
  logic                      neg_r, neg_nxt;
  logic [47:0]               mag_r, mag_nxt;
  logic [63:0]               macc_r, macc_nxt;
  logic signed [15:0]        x_r, x_nxt;
  logic                      lab_r, lab_nxt;
  logic signed [17:0]        err_r, err_nxt;
  logic                      res_kind_r, res_kind_nxt;
  logic                      res_class_r, res_class_nxt;

  // Output register
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_kind_r, out_kind_nxt;
  logic signed [31:0]        out_w_r, out_w_nxt, out_b_r, out_b_nxt;
  logic                      out_class_r, out_class_nxt;

  // Shared multiplier
  logic signed [32:0]        mul_a;
  logic signed [24:0]        mul_b;
  logic signed [PROD_W-1:0]  prod_r;

  // Store and divider
  logic                      st_we;
  lrt_pkg::sample_t          st_wdata, st_rdata;
  lrt_pkg::div_req_t         div_req;
  logic                      div_done;
  logic [lrt_pkg::DIV_W-1:0] div_q;

  // Combinational helpers
  logic                      accept;
  logic                      store_ok;
  logic signed [Z_W-1:0]     z_c, zs_c;
  logic [16:0]               p_c;
  logic signed [ACC_W-1:0]   wadd_c, badd_c, upd_c, delta_c;
  logic [63:0]               mtot_c;
  logic [47:0]               sum_sel_c;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign store_ok = (cnt_r < lrt_pkg::CNT_W'(lrt_pkg::MAX_SAMPLES));

  lrt_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (cnt_r[lrt_pkg::ADDR_W-1:0]),
    .wdata (st_wdata),
    .raddr (idx_r),
    .rdata (st_rdata)
  );

  lrt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // Store write on an accepted load that fits
  always_comb begin
    st_we          = accept && (in_op == lrt_pkg::OP_LOAD) && store_ok;
    st_wdata.x     = in_sample_x;
    st_wdata.label = (cnt_r != '0) && (in_sample_y > prev_y_r);
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MZ: begin
        mul_a = 33'(w_r);
        mul_b = 25'(st_rdata.x);
      end
      S_ME: begin
        mul_a = 33'(err_r);
        mul_b = 25'(x_r);
      end
      S_UMH: begin
        mul_a = $signed({17'd0, lr_r});
        mul_b = $signed({1'b0, mag_r[47:24]});
      end
      S_UML: begin
        mul_a = $signed({17'd0, lr_r});
        mul_b = $signed({1'b0, mag_r[23:0]});
      end
      S_PMUL: begin
        mul_a = 33'(w_r);
        mul_b = 25'(x_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // z = (w*x >> 8) + b, sigmoid, and the accumulator and update adds
  always_comb begin
    z_c       = $signed({prod_r[PROD_W-1], prod_r[PROD_W-1:8]}) + Z_W'(b_r);
    zs_c      = z_c >>> 4;
    p_c       = 17'd32768 + zs_c[16:0];
    wadd_c    = ACC_W'(wsum_r) + $signed(prod_r[PROD_W-1:8]);
    badd_c    = ACC_W'(bsum_r) + ACC_W'(err_r);
    mtot_c    = macc_r + {24'd0, prod_r[39:0]};
    sum_sel_c = sel_r ? bsum_r : wsum_r;
    delta_c   = neg_r ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
    upd_c     = (sel_r ? ACC_W'(b_r) : ACC_W'(w_r)) + delta_c;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    prev_y_nxt    = prev_y_r;
    w_nxt         = w_r;
    b_nxt         = b_r;
    wsum_nxt      = wsum_r;
    bsum_nxt      = bsum_r;
    idx_nxt       = idx_r;
    epoch_nxt     = epoch_r;
    sel_nxt       = sel_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    macc_nxt      = macc_r;
    x_nxt         = x_r;
    lab_nxt       = lab_r;
    err_nxt       = err_r;
    res_kind_nxt  = res_kind_r;
    res_class_nxt = res_class_r;
    div_req.start    = 1'b0;
    div_req.dividend = mtot_c[63:16];
    div_req.divisor  = n_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == lrt_pkg::OP_PREDICT) begin
            x_nxt     = in_sample_x;
            state_nxt = S_PMUL;
          end else begin
            if (store_ok) begin
              prev_y_nxt = in_sample_y;
              cnt_nxt    = cnt_r + 1'b1;
            end
            if (in_last) begin
              n_nxt         = store_ok ? cnt_r + 1'b1 : cnt_r;
              cnt_nxt       = '0;
              w_nxt         = '0;
              b_nxt         = '0;
              epoch_nxt     = '0;
              sel_nxt       = 1'b0;
              res_kind_nxt  = lrt_pkg::KIND_TRAIN;
              res_class_nxt = 1'b0;
              state_nxt     = (epochs_r == '0) ? S_EMIT : S_EP;
            end
          end
        end
      end
      // New epoch: clear the gradient sums
      S_EP: begin
        wsum_nxt  = '0;
        bsum_nxt  = '0;
        idx_nxt   = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_MZ;
      end
      S_MZ: begin
        x_nxt     = st_rdata.x;
        lab_nxt   = st_rdata.label;
        state_nxt = S_SIG;
      end
      // Piecewise linear sigmoid and error
      S_SIG: begin
        if (z_c <= SIG_LO) begin
          err_nxt = lab_r ? 18'sd65536 : 18'sd0;
        end else if (z_c >= SIG_HI) begin
          err_nxt = lab_r ? 18'sd0 : -18'sd65536;
        end else begin
          err_nxt = (lab_r ? 18'sd65536 : 18'sd0) - $signed({1'b0, p_c});
        end
        state_nxt = S_ME;
      end
      S_ME: begin
        state_nxt = S_ACC;
      end
      // Saturating accumulate
      S_ACC: begin
        if ((&wadd_c[ACC_W-1:47]) || !(|wadd_c[ACC_W-1:47])) begin
          wsum_nxt = wadd_c[47:0];
        end else begin
          wsum_nxt = wadd_c[ACC_W-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        if ((&badd_c[ACC_W-1:47]) || !(|badd_c[ACC_W-1:47])) begin
          bsum_nxt = badd_c[47:0];
        end else begin
          bsum_nxt = badd_c[ACC_W-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        if ({1'b0, idx_r} == n_r - 1'b1) begin
          state_nxt = S_UABS;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      // Update: |sum| * rate / (n * 65536), sign restored after
      S_UABS: begin
        neg_nxt   = sum_sel_c[47];
        mag_nxt   = sum_sel_c[47] ? (~sum_sel_c + 48'd1) : sum_sel_c;
        state_nxt = S_UMH;
      end
      S_UMH: begin
        state_nxt = S_UML;
      end
      S_UML: begin
        macc_nxt  = {prod_r[39:0], 24'd0};
        state_nxt = S_UMA;
      end
      S_UMA: begin
        div_req.start = 1'b1;
        state_nxt     = S_UDIV;
      end
      S_UDIV: begin
        if (div_done) begin
          state_nxt = S_UAPP;
        end
      end
      S_UAPP: begin
        if ((&upd_c[ACC_W-1:31]) || !(|upd_c[ACC_W-1:31])) begin
          if (sel_r) b_nxt = upd_c[31:0];
          else       w_nxt = upd_c[31:0];
        end else begin
          if (sel_r) b_nxt = upd_c[ACC_W-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
          else       w_nxt = upd_c[ACC_W-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        sel_nxt = !sel_r;
        if (!sel_r) begin
          state_nxt = S_UABS;
        end else begin
          epoch_nxt = epoch_r + 1'b1;
          state_nxt = (epoch_r + 1'b1 == epochs_r) ? S_EMIT : S_EP;
        end
      end
      S_PMUL: begin
        state_nxt = S_PZ;
      end
      S_PZ: begin
        res_kind_nxt  = lrt_pkg::KIND_PREDICT;
        res_class_nxt = (z_c > 0);
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_w_nxt     = out_w_r;
    out_b_nxt     = out_b_r;
    out_class_nxt = out_class_r;
    if ((state_r == S_EMIT) && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = res_kind_r;
      out_w_nxt     = w_r;
      out_b_nxt     = b_r;
      out_class_nxt = res_class_r;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lr_r        <= lrt_pkg::LR_RESET;
      epochs_r    <= lrt_pkg::EPOCH_RESET;
      cnt_r       <= '0;
      prev_y_r    <= '0;
      w_r         <= '0;
      b_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      prev_y_r    <= prev_y_nxt;
      w_r         <= w_nxt;
      b_r         <= b_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          lrt_pkg::REG_LR:    lr_r     <= cfg_wdata;
          lrt_pkg::REG_EPOCH: epochs_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    wsum_r      <= wsum_nxt;
    bsum_r      <= bsum_nxt;
    idx_r       <= idx_nxt;
    epoch_r     <= epoch_nxt;
    sel_r       <= sel_nxt;
    neg_r       <= neg_nxt;
    mag_r       <= mag_nxt;
    macc_r      <= macc_nxt;
    x_r         <= x_nxt;
    lab_r       <= lab_nxt;
    err_r       <= err_nxt;
    res_kind_r  <= res_kind_nxt;
    res_class_r <= res_class_nxt;
    out_kind_r  <= out_kind_nxt;
    out_w_r     <= out_w_nxt;
    out_b_r     <= out_b_nxt;
    out_class_r <= out_class_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_weight_out      = out_w_r;
  assign out_bias_out        = out_b_r;
  assign out_predicted_class = out_class_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lrt_checker.sv =====
// ---------------------------------------------------------------------------
// lrt_checker
// Port-level checks for the logistic regression trainer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "logistic_regression_trainer_assert.svh"

module lrt_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_ready,
  input wire                in_op,
  input wire signed [15:0]  in_sample_x,
  input wire signed [15:0]  in_sample_y,
  input wire                in_last,
  input wire                out_valid,
  input wire                out_ready,
  input wire                out_kind,
  input wire signed [31:0]  out_weight_out,
  input wire signed [31:0]  out_bias_out,
  input wire                out_predicted_class,
  input wire                cfg_we,
  input wire [0:0]          cfg_index,
  input wire [15:0]         cfg_wdata
);

  // A stalled result holds
  `LRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_weight_out) && $stable(out_bias_out))

  // Training results never carry a class
  `LRT_ASSERT(a_train_class, (out_valid && (out_kind == 1'b0)) |-> !out_predicted_class)

  // A predict request holds off the next request
  `LRT_ASSERT_NEXT(a_pred_busy, in_valid && in_ready && in_op, !in_ready)

  // A final load request holds off the next request and trains if epochs > 0
  `LRT_ASSERT_NEXT(a_train_busy, in_valid && in_ready && !in_op && in_last, !in_ready)

endmodule

bind logistic_regression_trainer lrt_checker u_lrt_checker (.*);

`default_nettype wire
